// ===== hdl/assert_macros.svh =====
// assertion macros shared by the history window matcher rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/hbwm_pkg.sv =====
// shared types and constants of the byte history window matcher
`default_nettype none

package hbwm_pkg;

    localparam int unsigned BUF_DEPTH_DEF = 4096;

    // offset field and the dividend widened by one bit for offset-1 and offset-2
    localparam int OFF_W  = 17;
    localparam int DIVD_W = OFF_W + 1;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    // input beat layout
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 2;
    localparam int BYTE_LSB   = 0;
    localparam int OFF_LSB    = 8;
    localparam int PAT_LSB    = 25;
    localparam int PLEN_LSB   = 89;
    localparam int PAT_W      = 64;
    localparam int PLEN_W     = 4;
    localparam int MAX_PLEN   = 8;

    // output beat layout, the held count width follows the ring depth
    localparam int VALUE_W     = 16;
    localparam int TOTAL_W     = 32;
    localparam int OUT_FIXED_W = VALUE_W + 1 + TOTAL_W;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_SUFFIX = 2'd2,
        ACT_READ16 = 2'd3
    } action_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIVD_W-1:0] dividend;
    } div_req_t;

endpackage

`default_nettype wire

// ===== hdl/hbwm_ram.sv =====
// byte ring storage with one write port and one registered read port
`default_nettype none

module hbwm_ram #(
    parameter int unsigned DEPTH = hbwm_pkg::BUF_DEPTH_DEF,
    parameter int          AW    = $clog2(hbwm_pkg::BUF_DEPTH_DEF)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hbwm_divider.sv =====
// bit-serial remainder unit turning a signed offset into a lookback distance
`default_nettype none

module hbwm_divider #(
    parameter int HW = $clog2(hbwm_pkg::BUF_DEPTH_DEF + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hbwm_pkg::div_req_t req,
    input  logic [HW-1:0]      divisor,
    output logic               done,
    output logic [HW-1:0]      back
);

    import hbwm_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              neg_reg;
    logic              neg_next;
    logic [DIVD_W-1:0] mag_reg;
    logic [DIVD_W-1:0] mag_next;
    logic [HW-1:0]     rem_reg;
    logic [HW-1:0]     rem_next;
    logic [HW-1:0]     div_reg;
    logic [HW-1:0]     div_next;
    logic [HW:0]       shifted;
    logic [HW:0]       trial;

    assign shifted = {rem_reg, mag_reg[DIVD_W-1]};
    assign trial   = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVD_W);
            neg_next  = req.dividend[DIVD_W-1];
            mag_next  = req.dividend[DIVD_W-1] ? DIVD_W'(-req.dividend)
                                               : DIVD_W'(req.dividend);
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                // one quotient bit per cycle, restoring form
                cnt_next = cnt_reg - 1'b1;
                mag_next = {mag_reg[DIVD_W-2:0], 1'b0};
                rem_next = trial[HW] ? shifted[HW-1:0] : trial[HW-1:0];
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // negative nonzero remainder counts back directly, otherwise from the held count
    assign done = busy_reg && (cnt_reg == '0);
    assign back = (neg_reg && (rem_reg != '0)) ? rem_reg : div_reg - rem_reg;

endmodule

`default_nettype wire

// ===== hdl/byte_history_window_matcher_core.sv =====
// top level of the byte history window matcher: sequencer, counters and output stage
//
// one input beat on s_axis carries one request, action in tuser: push a byte,
// read a byte at a signed lookback offset, test the newest bytes against a
// pattern of 1 to 8 bytes, or read a little-endian 16-bit value ending at an
// offset. every request gives exactly one beat on m_axis with the value, the
// match flag, the held count and the running total after the request.
// s_axis_tready is high only while no request is in progress.
// a byte read waits on the bit-serial remainder unit (one bit of the 18-bit
// dividend per cycle); a 16-bit read runs that unit twice. a suffix test makes
// one ring read per compared byte through the registered port.
// an empty ring answers a read at once with 0.
// reset clears the counters and the write position; ring contents are not
// cleared, only written entries are ever read.
// a stalled receiver holds the result in the output register; a finished
// request then waits in the done state, and the input stays closed, until the beat is taken.
`default_nettype none
`include "assert_macros.svh"

module byte_history_window_matcher_core #(
    parameter int unsigned BUF_DEPTH = hbwm_pkg::BUF_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // byte_in, offset, pattern, pattern_len, zero pad
    input  logic [hbwm_pkg::IN_DATA_W-1:0]          s_axis_tdata,
    // action
    input  logic [hbwm_pkg::IN_USER_W-1:0]          s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // value, matched, held_count, total_count, zero pad
    output logic [(hbwm_pkg::OUT_FIXED_W + $clog2(BUF_DEPTH + 1) + 7) / 8 * 8 - 1:0]
                                                    m_axis_tdata
);

    import hbwm_pkg::*;

    localparam int AW    = $clog2(BUF_DEPTH);
    localparam int HW    = $clog2(BUF_DEPTH + 1);
    localparam int OUT_W = (OUT_FIXED_W + HW + 7) / 8 * 8;
    localparam int MATCH_BIT = VALUE_W;
    localparam int HELD_LSB  = VALUE_W + 1;
    localparam int TOTAL_LSB = VALUE_W + 1 + HW;

    localparam logic [AW-1:0] LAST_POS = AW'(BUF_DEPTH - 1);
    localparam logic [HW-1:0] HELD_MAX = HW'(BUF_DEPTH);
    localparam logic [HW:0]   DEPTH_V  = (HW + 1)'(BUF_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_ADDR = 5'b00100,
        ST_DATA = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    action_t             act_reg;
    action_t             act_next;
    logic                phase_reg;
    logic                phase_next;
    logic [OFF_W-1:0]    off_reg;
    logic [OFF_W-1:0]    off_next;
    logic [PAT_W-1:0]    pat_reg;
    logic [PAT_W-1:0]    pat_next;
    logic [PLEN_W-1:0]   plen_reg;
    logic [PLEN_W-1:0]   plen_next;
    logic [HW-1:0]       k_reg;
    logic [HW-1:0]       k_next;
    logic [VALUE_W-1:0]  val_reg;
    logic [VALUE_W-1:0]  val_next;
    logic                match_reg;
    logic                match_next;
    logic [AW-1:0]       wp_reg;
    logic [AW-1:0]       wp_next;
    logic [HW-1:0]       held_reg;
    logic [HW-1:0]       held_next;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OUT_W-1:0]    out_data_reg;
    logic [OUT_W-1:0]    out_data_next;
    logic [OUT_W-1:0]    out_word;

    logic                in_acc;
    action_t             in_act;
    logic [7:0]          in_byte;
    logic [OFF_W-1:0]    in_off;
    logic [PLEN_W-1:0]   in_plen;
    logic                plen_bad;

    div_req_t            div_req;
    logic                div_done;
    logic [HW-1:0]       div_back;

    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [7:0]          ram_rd_data;
    logic [HW:0]         pos_diff;
    logic [HW:0]         pos_full;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_act        = action_t'(s_axis_tuser);
    assign in_byte       = s_axis_tdata[BYTE_LSB +: 8];
    assign in_off        = s_axis_tdata[OFF_LSB +: OFF_W];
    assign in_plen       = s_axis_tdata[PLEN_LSB +: PLEN_W];

    // pattern longer than the history or outside one to eight bytes
    assign plen_bad = (in_plen == '0) || (in_plen > PLEN_W'(MAX_PLEN))
                   || ({{HW{1'b0}}, in_plen} > {{PLEN_W{1'b0}}, held_reg});

    // ring position k bytes back from the write position
    assign pos_diff    = {{(HW + 1 - AW){1'b0}}, wp_reg} - {1'b0, k_reg};
    assign pos_full    = pos_diff[HW] ? pos_diff + DEPTH_V : pos_diff;
    assign ram_rd_addr = pos_full[AW-1:0];
    assign ram_rd_en   = (state_reg == ST_ADDR);
    assign ram_wr_en   = in_acc && (in_act == ACT_PUSH);

    always_comb
    begin
        out_word = '0;
        out_word[0 +: VALUE_W]   = val_reg;
        out_word[MATCH_BIT]      = match_reg;
        out_word[HELD_LSB +: HW] = held_reg;
        out_word[TOTAL_LSB +: TOTAL_W] = total_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        phase_next     = phase_reg;
        off_next       = off_reg;
        pat_next       = pat_reg;
        plen_next      = plen_reg;
        k_next         = k_reg;
        val_next       = val_reg;
        match_next     = match_reg;
        wp_next        = wp_reg;
        held_next      = held_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {off_reg[OFF_W-1], off_reg} - DIVD_W'(2);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    act_next   = in_act;
                    off_next   = in_off;
                    pat_next   = s_axis_tdata[PAT_LSB +: PAT_W];
                    plen_next  = in_plen;
                    phase_next = 1'b0;
                    val_next   = '0;
                    match_next = 1'b0;
                    k_next     = HW'(1);
                    state_next = ST_DONE;
                    unique case (in_act)
                        ACT_PUSH:
                        begin
                            total_next = total_reg + 1'b1;
                            wp_next    = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;
                            if (held_reg != HELD_MAX)
                            begin
                                held_next = held_reg + 1'b1;
                            end
                        end
                        ACT_READ:
                        begin
                            if (held_reg != '0)
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = {in_off[OFF_W-1], in_off};
                                state_next       = ST_DIV;
                            end
                        end
                        ACT_READ16:
                        begin
                            if (held_reg != '0)
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = {in_off[OFF_W-1], in_off} - DIVD_W'(1);
                                state_next       = ST_DIV;
                            end
                        end
                        ACT_SUFFIX:
                        begin
                            if (!plen_bad)
                            begin
                                state_next = ST_ADDR;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    k_next     = div_back;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                case (act_reg)
                    ACT_READ:
                    begin
                        val_next   = {8'h00, ram_rd_data};
                        state_next = ST_DONE;
                    end
                    ACT_READ16:
                    begin
                        if (!phase_reg)
                        begin
                            val_next[15:8] = ram_rd_data;
                            phase_next     = 1'b1;
                            div_req.start  = 1'b1;
                            state_next     = ST_DIV;
                        end
                        else
                        begin
                            val_next[7:0] = ram_rd_data;
                            state_next    = ST_DONE;
                        end
                    end
                    default:
                    begin
                        if (ram_rd_data != pat_reg[7:0])
                        begin
                            match_next = 1'b0;
                            state_next = ST_DONE;
                        end
                        else if (k_reg == HW'(plen_reg))
                        begin
                            match_next = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            k_next     = k_reg + 1'b1;
                            pat_next   = {8'h00, pat_reg[PAT_W-1:8]};
                            state_next = ST_ADDR;
                        end
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = out_word;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            held_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            held_reg      <= held_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        phase_reg    <= phase_next;
        off_reg      <= off_next;
        pat_reg      <= pat_next;
        plen_reg     <= plen_next;
        k_reg        <= k_next;
        val_reg      <= val_next;
        match_reg    <= match_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    hbwm_divider #(
        .HW (HW)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (held_reg),
        .done    (div_done),
        .back    (div_back)
    );

    hbwm_ram #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (in_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    `ASSERT_ALWAYS(a_held_max, clk, rst_n, held_reg <= HELD_MAX)
    `ASSERT_NEXT(a_push_total, clk, rst_n, in_acc && (in_act == ACT_PUSH), total_reg == $past(total_reg) + 32'd1)
    `ASSERT_IMPLIES(a_div_state, clk, rst_n, div_done, state_reg == ST_DIV)

endmodule

`default_nettype wire
